FILE: design/ufc_pkg.sv
// shared types and constants for the uart fifo controller
// no dependencies; used by ufc_ctrl, ufc_dp and uart_fifo_controller_core
package ufc_pkg;

  // ring depths
  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;

  // slot address, wrap pointer and level widths
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_PW = $clog2(2 * RX_DEPTH);
  localparam int TX_PW = $clog2(2 * TX_DEPTH);

  // fixed field widths
  localparam int BYTE_W  = 8;
  localparam int TYPE_W  = 3;
  localparam int LEVEL_W = 7;
  localparam int CNT_W   = 16;
  localparam int TRIG_W  = 6;
  localparam int CFG_W   = 6;

  localparam logic [TRIG_W-1:0] RX_TRIG_RST = 6'd16;

  // request codes
  typedef enum logic [TYPE_W-1:0] {
    REQ_RX_BYTE  = 3'd0,
    REQ_RX_BREAK = 3'd1,
    REQ_RX_IDLE  = 3'd2,
    REQ_TX_READY = 3'd3,
    REQ_HOST_WR  = 3'd4,
    REQ_HOST_RD  = 3'd5,
    REQ_EVENT    = 3'd6
  } req_e;

  // configuration register indexes
  typedef enum logic {
    CFG_RX_TRIGGER = 1'b0,
    CFG_BREAK_MODE = 1'b1
  } cfg_e;

  // controller to datapath commands
  typedef struct packed {
    logic step;
  } cmd_t;

endpackage

FILE: design/ufc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ufc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ufc_ctrl.sv
// handshake controller: one-hot fsm that takes a word and holds its result
// depends on ufc_pkg
module ufc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ufc_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   step;

  // a held result may be replaced in the cycle it is taken
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_HOLD: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign step       = in_valid_i && in_ready_o;
  assign cmd_o.step = step;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (step) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready_i && !step) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/ufc_dp.sv
// datapath: ring pointers, ring memories, counters, config registers, result flags
// depends on ufc_pkg and ufc_ram
module ufc_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ufc_pkg::cmd_t                  cmd_i,
  input  logic [ufc_pkg::TYPE_W-1:0]     req_type_i,
  input  logic [ufc_pkg::BYTE_W-1:0]     data_in_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [ufc_pkg::CFG_W-1:0]      cfg_data_i,
  output logic [ufc_pkg::BYTE_W-1:0]     data_out_o,
  output logic                           data_valid_o,
  output logic                           rx_notify_o,
  output logic                           tx_notify_o,
  output logic [ufc_pkg::LEVEL_W-1:0]    rx_level_o,
  output logic [ufc_pkg::LEVEL_W-1:0]    tx_level_o,
  output logic                           tx_active_o,
  output logic                           write_rejected_o,
  output logic                           read_empty_o,
  output logic                           rx_dropped_o,
  output logic [ufc_pkg::CNT_W-1:0]      drop_total_o,
  output logic [ufc_pkg::CNT_W-1:0]      overrun_total_o
);

  localparam int RPW = ufc_pkg::RX_PW;
  localparam int TPW = ufc_pkg::TX_PW;
  localparam int RAW = ufc_pkg::RX_AW;
  localparam int TAW = ufc_pkg::TX_AW;
  localparam int RD  = ufc_pkg::RX_DEPTH;
  localparam int TD  = ufc_pkg::TX_DEPTH;

  logic [RPW-1:0] rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d;
  logic [TPW-1:0] tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d;
  logic           irq_q, irq_d;
  logic [ufc_pkg::CNT_W-1:0] drop_q, drop_d, ovr_q, ovr_d;
  logic [ufc_pkg::TRIG_W-1:0] trig_q;
  logic           brk_q;

  logic dvalid_q, dvalid_d, rxn_q, rxn_d, txn_q, txn_d;
  logic wrej_q, wrej_d, rempty_q, rempty_d, rdrop_q, rdrop_d;
  logic sel_tx_q, sel_tx_d;

  logic [RPW:0]   rx_lvl, rx_free;
  logic [TPW:0]   tx_lvl;
  logic           rx_full, rx_empty, tx_full, tx_empty;
  logic [RPW-1:0] rx_wp_inc, rx_wp_dec, rx_rp_inc, rx_wslot, rx_rslot;
  logic [TPW-1:0] tx_wp_inc, tx_rp_inc, tx_wslot, tx_rslot;
  logic           rx_we, rx_re, tx_we, tx_re;
  logic [ufc_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;
  ufc_pkg::req_e  req;

  assign req = ufc_pkg::req_e'(req_type_i);

  // levels: pointers wrap at twice the depth
  assign rx_lvl = (rx_wp_q >= rx_rp_q) ? ({1'b0, rx_wp_q} - {1'b0, rx_rp_q})
                : ({1'b0, rx_wp_q} + (RPW+1)'(2 * RD) - {1'b0, rx_rp_q});
  assign tx_lvl = (tx_wp_q >= tx_rp_q) ? ({1'b0, tx_wp_q} - {1'b0, tx_rp_q})
                : ({1'b0, tx_wp_q} + (TPW+1)'(2 * TD) - {1'b0, tx_rp_q});

  assign rx_full  = (rx_lvl == (RPW+1)'(RD));
  assign tx_full  = (tx_lvl == (TPW+1)'(TD));
  assign rx_empty = (rx_wp_q == rx_rp_q);
  assign tx_empty = (tx_wp_q == tx_rp_q);
  assign rx_free  = (RPW+1)'(RD) - rx_lvl - 1'b1;

  assign rx_wp_inc = (rx_wp_q == RPW'(2 * RD - 1)) ? '0 : rx_wp_q + 1'b1;
  assign rx_wp_dec = (rx_wp_q == '0) ? RPW'(2 * RD - 1) : rx_wp_q - 1'b1;
  assign rx_rp_inc = (rx_rp_q == RPW'(2 * RD - 1)) ? '0 : rx_rp_q + 1'b1;
  assign tx_wp_inc = (tx_wp_q == TPW'(2 * TD - 1)) ? '0 : tx_wp_q + 1'b1;
  assign tx_rp_inc = (tx_rp_q == TPW'(2 * TD - 1)) ? '0 : tx_rp_q + 1'b1;

  // slot is pointer modulo depth
  assign rx_wslot = (rx_wp_q >= RPW'(RD)) ? rx_wp_q - RPW'(RD) : rx_wp_q;
  assign rx_rslot = (rx_rp_q >= RPW'(RD)) ? rx_rp_q - RPW'(RD) : rx_rp_q;
  assign tx_wslot = (tx_wp_q >= TPW'(TD)) ? tx_wp_q - TPW'(TD) : tx_wp_q;
  assign tx_rslot = (tx_rp_q >= TPW'(TD)) ? tx_rp_q - TPW'(TD) : tx_rp_q;

  always_comb begin
    rx_wp_d  = rx_wp_q;
    rx_rp_d  = rx_rp_q;
    tx_wp_d  = tx_wp_q;
    tx_rp_d  = tx_rp_q;
    irq_d    = irq_q;
    drop_d   = drop_q;
    ovr_d    = ovr_q;
    dvalid_d = dvalid_q;
    rxn_d    = rxn_q;
    txn_d    = txn_q;
    wrej_d   = wrej_q;
    rempty_d = rempty_q;
    rdrop_d  = rdrop_q;
    sel_tx_d = sel_tx_q;
    rx_we    = 1'b0;
    rx_re    = 1'b0;
    tx_we    = 1'b0;
    tx_re    = 1'b0;
    if (cmd_i.step) begin
      dvalid_d = 1'b0;
      rxn_d    = 1'b0;
      txn_d    = 1'b0;
      wrej_d   = 1'b0;
      rempty_d = 1'b0;
      rdrop_d  = 1'b0;
      sel_tx_d = 1'b0;
      case (req)
        ufc_pkg::REQ_RX_BYTE: begin
          if (!rx_full) begin
            rx_we   = 1'b1;
            rx_wp_d = rx_wp_inc;
            rxn_d   = (rx_free == (RPW+1)'(trig_q));
          end else begin
            rdrop_d = 1'b1;
            drop_d  = (drop_q == '1) ? drop_q : drop_q + 1'b1;
          end
        end
        ufc_pkg::REQ_RX_BREAK: begin
          // drop newest byte, guarded on empty ring
          if (!rx_empty) rx_wp_d = rx_wp_dec;
          rxn_d = 1'b1;
        end
        ufc_pkg::REQ_RX_IDLE: begin
          rxn_d = !brk_q;
        end
        ufc_pkg::REQ_TX_READY: begin
          if (irq_q) begin
            if (tx_empty) begin
              irq_d = 1'b0;
              txn_d = 1'b1;
            end else begin
              tx_re    = 1'b1;
              tx_rp_d  = tx_rp_inc;
              dvalid_d = 1'b1;
              sel_tx_d = 1'b1;
            end
          end
        end
        ufc_pkg::REQ_HOST_WR: begin
          if (!tx_full) begin
            tx_we   = 1'b1;
            tx_wp_d = tx_wp_inc;
          end else begin
            wrej_d = 1'b1;
          end
          irq_d = 1'b1;
        end
        ufc_pkg::REQ_HOST_RD: begin
          if (rx_empty) begin
            rempty_d = 1'b1;
          end else begin
            rx_re    = 1'b1;
            rx_rp_d  = rx_rp_inc;
            dvalid_d = 1'b1;
          end
        end
        ufc_pkg::REQ_EVENT: begin
          if (data_in_i[0]) begin
            tx_wp_d = '0;
            tx_rp_d = '0;
          end else begin
            ovr_d = (ovr_q == '1) ? ovr_q : ovr_q + 1'b1;
          end
        end
        default: begin
          // unused code: levels and totals only
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wp_q  <= '0;
      rx_rp_q  <= '0;
      tx_wp_q  <= '0;
      tx_rp_q  <= '0;
      irq_q    <= 1'b0;
      drop_q   <= '0;
      ovr_q    <= '0;
      dvalid_q <= 1'b0;
      rxn_q    <= 1'b0;
      txn_q    <= 1'b0;
      wrej_q   <= 1'b0;
      rempty_q <= 1'b0;
      rdrop_q  <= 1'b0;
      sel_tx_q <= 1'b0;
    end else begin
      rx_wp_q  <= rx_wp_d;
      rx_rp_q  <= rx_rp_d;
      tx_wp_q  <= tx_wp_d;
      tx_rp_q  <= tx_rp_d;
      irq_q    <= irq_d;
      drop_q   <= drop_d;
      ovr_q    <= ovr_d;
      dvalid_q <= dvalid_d;
      rxn_q    <= rxn_d;
      txn_q    <= txn_d;
      wrej_q   <= wrej_d;
      rempty_q <= rempty_d;
      rdrop_q  <= rdrop_d;
      sel_tx_q <= sel_tx_d;
    end
  end

  // config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q <= ufc_pkg::RX_TRIG_RST;
      brk_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (ufc_pkg::cfg_e'(cfg_index_i))
        ufc_pkg::CFG_RX_TRIGGER: begin
          trig_q <= (int'(cfg_data_i) < RD) ? ufc_pkg::TRIG_W'(cfg_data_i) : '0;
        end
        ufc_pkg::CFG_BREAK_MODE: begin
          brk_q <= cfg_data_i[0];
        end
        default: begin
          brk_q <= brk_q;
        end
      endcase
    end
  end

  ufc_ram #(
    .WIDTH(ufc_pkg::BYTE_W),
    .DEPTH(RD)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .we_i   (rx_we),
    .waddr_i(rx_wslot[RAW-1:0]),
    .wdata_i(data_in_i),
    .re_i   (rx_re),
    .raddr_i(rx_rslot[RAW-1:0]),
    .rdata_o(rx_rdata)
  );

  ufc_ram #(
    .WIDTH(ufc_pkg::BYTE_W),
    .DEPTH(TD)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (tx_we),
    .waddr_i(tx_wslot[TAW-1:0]),
    .wdata_i(data_in_i),
    .re_i   (tx_re),
    .raddr_i(tx_rslot[TAW-1:0]),
    .rdata_o(tx_rdata)
  );

  // state only moves on a step, so levels and totals read straight from it
  assign data_out_o       = dvalid_q ? (sel_tx_q ? tx_rdata : rx_rdata) : '0;
  assign data_valid_o     = dvalid_q;
  assign rx_notify_o      = rxn_q;
  assign tx_notify_o      = txn_q;
  assign rx_level_o       = ufc_pkg::LEVEL_W'(rx_lvl);
  assign tx_level_o       = ufc_pkg::LEVEL_W'(tx_lvl);
  assign tx_active_o      = irq_q;
  assign write_rejected_o = wrej_q;
  assign read_empty_o     = rempty_q;
  assign rx_dropped_o     = rdrop_q;
  assign drop_total_o     = drop_q;
  assign overrun_total_o  = ovr_q;

  a_rx_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_lvl <= (RPW+1)'(RD))
    else $error("receive level above depth");

  a_tx_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_lvl <= (TPW+1)'(TD))
    else $error("transmit level above depth");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdrop_q |-> rx_full)
    else $error("drop reported with room in receive ring");

  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rempty_q |-> rx_empty)
    else $error("empty read reported with bytes held");

  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvalid_q |-> !(rempty_q || wrej_q || rdrop_q || txn_q))
    else $error("data word flagged together with a refusal");

endmodule

FILE: design/uart_fifo_controller_core.sv
// top level of the uart fifo controller: receive and transmit rings with trigger level
// depends on ufc_pkg, ufc_ctrl, ufc_dp (which holds two ufc_ram instances)
// result: registered at the edge that takes the word, valid from the next cycle
// throughput: one word per cycle while out_ready_i stays high; with the output
//   stalled the held result blocks input, since the ring ram read data sits in it
// reset: pointers, counters and flags clear, rx_trigger loads 16, break_mode 0;
//   ring contents stay undefined until written, no clearing pass
module uart_fifo_controller_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request words
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ufc_pkg::TYPE_W-1:0]  req_type_i,
  input  logic [ufc_pkg::BYTE_W-1:0]  data_in_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ufc_pkg::BYTE_W-1:0]  data_out_o,
  output logic                        data_valid_o,
  output logic                        rx_notify_o,
  output logic                        tx_notify_o,
  output logic [ufc_pkg::LEVEL_W-1:0] rx_level_o,
  output logic [ufc_pkg::LEVEL_W-1:0] tx_level_o,
  output logic                        tx_active_o,
  output logic                        write_rejected_o,
  output logic                        read_empty_o,
  output logic                        rx_dropped_o,
  output logic [ufc_pkg::CNT_W-1:0]   drop_total_o,
  output logic [ufc_pkg::CNT_W-1:0]   overrun_total_o,
  // configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [ufc_pkg::CFG_W-1:0]   cfg_data_i
);

  // step command: the dp updates pointers, counters, ram and result
  // flags at the same edge the controller takes the word
  ufc_pkg::cmd_t cmd;

  // handshake control, holds the result until the consumer takes it
  ufc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  // rings, counters and config registers; ram read data lands with the flags
  ufc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .req_type_i      (req_type_i),
    .data_in_i       (data_in_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .data_out_o      (data_out_o),
    .data_valid_o    (data_valid_o),
    .rx_notify_o     (rx_notify_o),
    .tx_notify_o     (tx_notify_o),
    .rx_level_o      (rx_level_o),
    .tx_level_o      (tx_level_o),
    .tx_active_o     (tx_active_o),
    .write_rejected_o(write_rejected_o),
    .read_empty_o    (read_empty_o),
    .rx_dropped_o    (rx_dropped_o),
    .drop_total_o    (drop_total_o),
    .overrun_total_o (overrun_total_o)
  );

endmodule

FILE: tb/sv/ufc_tb_pkg.sv
// result word type and ring scoreboard for the uart fifo controller testbench
// depends on ufc_pkg for widths, depths and request codes
package ufc_tb_pkg;
  import ufc_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0]  data_out;
    logic               data_valid;
    logic               rx_notify;
    logic               tx_notify;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
    logic               tx_active;
    logic               write_rejected;
    logic               read_empty;
    logic               rx_dropped;
    logic [CNT_W-1:0]   drop_total;
    logic [CNT_W-1:0]   overrun_total;
  } ufc_reply_t;

  class ufc_ring_scoreboard;
    logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
    logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
    logic [RX_PW-1:0]  rx_wp, rx_rp;
    logic [TX_PW-1:0]  tx_wp, tx_rp;
    logic              tx_irq;
    logic [CNT_W-1:0]  drops, overruns;
    logic [TRIG_W-1:0] trigger;
    logic              break_framing;
    ufc_reply_t        due_words [$];
    int unsigned       fail_count;
    int unsigned       report_count;

    function new();
      foreach (rx_mem[i]) rx_mem[i] = '0;
      foreach (tx_mem[i]) tx_mem[i] = '0;
      rx_wp = '0;
      rx_rp = '0;
      tx_wp = '0;
      tx_rp = '0;
      tx_irq = 1'b0;
      drops = '0;
      overruns = '0;
      trigger = RX_TRIG_RST;
      break_framing = 1'b0;
      fail_count = 0;
      report_count = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == CFG_RX_TRIGGER) begin
        trigger = (val < RX_DEPTH) ? val[TRIG_W-1:0] : '0;
      end else begin
        break_framing = val[0];
      end
    endfunction

    // next ring state and the word it reports
    function ufc_reply_t advance_rings(logic [TYPE_W-1:0] kind, logic [BYTE_W-1:0] din);
      ufc_reply_t r;
      int unsigned lvl;
      r = '{default: '0};
      case (kind)
        REQ_RX_BYTE: begin
          lvl = RX_PW'(rx_wp - rx_rp);
          if (lvl < RX_DEPTH) begin
            rx_mem[rx_wp[RX_AW-1:0]] = din;
            rx_wp = rx_wp + 1'b1;
            if (RX_DEPTH - (lvl + 1) == int'(trigger)) r.rx_notify = 1'b1;
          end else begin
            r.rx_dropped = 1'b1;
            if (drops != '1) drops = drops + 1'b1;
          end
        end
        REQ_RX_BREAK: begin
          if (rx_wp != rx_rp) rx_wp = rx_wp - 1'b1;
          r.rx_notify = 1'b1;
        end
        REQ_RX_IDLE: begin
          if (!break_framing) r.rx_notify = 1'b1;
        end
        REQ_TX_READY: begin
          if (tx_irq) begin
            if (tx_wp == tx_rp) begin
              tx_irq = 1'b0;
              r.tx_notify = 1'b1;
            end else begin
              r.data_out = tx_mem[tx_rp[TX_AW-1:0]];
              r.data_valid = 1'b1;
              tx_rp = tx_rp + 1'b1;
            end
          end
        end
        REQ_HOST_WR: begin
          lvl = TX_PW'(tx_wp - tx_rp);
          if (lvl < TX_DEPTH) begin
            tx_mem[tx_wp[TX_AW-1:0]] = din;
            tx_wp = tx_wp + 1'b1;
          end else begin
            r.write_rejected = 1'b1;
          end
          tx_irq = 1'b1;
        end
        REQ_HOST_RD: begin
          if (rx_wp == rx_rp) begin
            r.read_empty = 1'b1;
          end else begin
            r.data_out = rx_mem[rx_rp[RX_AW-1:0]];
            r.data_valid = 1'b1;
            rx_rp = rx_rp + 1'b1;
          end
        end
        REQ_EVENT: begin
          if (din[0]) begin
            tx_wp = '0;
            tx_rp = '0;
          end else if (overruns != '1) begin
            overruns = overruns + 1'b1;
          end
        end
        default: ;
      endcase
      r.rx_level = LEVEL_W'(RX_PW'(rx_wp - rx_rp));
      r.tx_level = LEVEL_W'(TX_PW'(tx_wp - tx_rp));
      r.tx_active = tx_irq;
      r.drop_total = drops;
      r.overrun_total = overruns;
      return r;
    endfunction

    function void note_request(logic [TYPE_W-1:0] kind, logic [BYTE_W-1:0] din);
      due_words.push_back(advance_rings(kind, din));
    endfunction

    function void flag(string msg, time stamp);
      fail_count++;
      if (report_count < 40) begin
        report_count++;
        $display("%0t: %s", stamp, msg);
      end
    endfunction

    function void field_check(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got,
                              time stamp);
      if (want !== got) begin
        flag($sformatf("%s mismatch, expected %0h actual %0h", name, want, got), stamp);
      end
    endfunction

    function void check_word(ufc_reply_t got, time stamp);
      ufc_reply_t want;
      if (due_words.size() == 0) begin
        flag("result word with nothing expected", stamp);
        return;
      end
      want = due_words.pop_front();
      field_check("data_out", want.data_out, got.data_out, stamp);
      field_check("data_valid", want.data_valid, got.data_valid, stamp);
      field_check("rx_notify", want.rx_notify, got.rx_notify, stamp);
      field_check("tx_notify", want.tx_notify, got.tx_notify, stamp);
      field_check("rx_level", want.rx_level, got.rx_level, stamp);
      field_check("tx_level", want.tx_level, got.tx_level, stamp);
      field_check("tx_active", want.tx_active, got.tx_active, stamp);
      field_check("write_rejected", want.write_rejected, got.write_rejected, stamp);
      field_check("read_empty", want.read_empty, got.read_empty, stamp);
      field_check("rx_dropped", want.rx_dropped, got.rx_dropped, stamp);
      field_check("drop_total", want.drop_total, got.drop_total, stamp);
      field_check("overrun_total", want.overrun_total, got.overrun_total, stamp);
    endfunction

    function void leftover_check(time stamp);
      if (due_words.size() != 0) begin
        flag($sformatf("%0d expected words never arrived", due_words.size()), stamp);
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_top.sv
// top-level testbench for uart_fifo_controller_core: drives request and config words,
// predicts every result word with the ring scoreboard from ufc_tb_pkg, needs ufc_pkg
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ufc_pkg::*;
  import ufc_tb_pkg::*;

  // reserved request code, not part of req_e, the block must ignore it
  localparam logic [TYPE_W-1:0] REQ_RESERVED = 3'd7;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [TYPE_W-1:0]   req_type_i = '0;
  logic [BYTE_W-1:0]   data_in_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [BYTE_W-1:0]   data_out_o;
  logic                data_valid_o;
  logic                rx_notify_o;
  logic                tx_notify_o;
  logic [LEVEL_W-1:0]  rx_level_o;
  logic [LEVEL_W-1:0]  tx_level_o;
  logic                tx_active_o;
  logic                write_rejected_o;
  logic                read_empty_o;
  logic                rx_dropped_o;
  logic [CNT_W-1:0]    drop_total_o;
  logic [CNT_W-1:0]    overrun_total_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i = CFG_RX_TRIGGER;
  logic [CFG_W-1:0]    cfg_data_i = '0;

  // per-cycle idle chances in percent, sender and receiver side
  int unsigned send_idle = 6;
  int unsigned recv_idle = 63;

  ufc_ring_scoreboard sb = new();

  uart_fifo_controller_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .data_in_i        (data_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_out_o       (data_out_o),
    .data_valid_o     (data_valid_o),
    .rx_notify_o      (rx_notify_o),
    .tx_notify_o      (tx_notify_o),
    .rx_level_o       (rx_level_o),
    .tx_level_o       (tx_level_o),
    .tx_active_o      (tx_active_o),
    .write_rejected_o (write_rejected_o),
    .read_empty_o     (read_empty_o),
    .rx_dropped_o     (rx_dropped_o),
    .drop_total_o     (drop_total_o),
    .overrun_total_o  (overrun_total_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("uart_fifo_controller_core test failed");
    $finish;
  end

  // receiver stalls at random, chance set by recv_idle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
  end

  // handshake monitor: everything sampled at the edge, before any update lands
  always @(posedge clk_i) begin : watch
    ufc_reply_t seen;
    if (rst_ni) begin
      // result first, a word accepted now shows up in the following cycle at the earliest
      if (out_valid_o && out_ready_i) begin
        seen.data_out       = data_out_o;
        seen.data_valid     = data_valid_o;
        seen.rx_notify      = rx_notify_o;
        seen.tx_notify      = tx_notify_o;
        seen.rx_level       = rx_level_o;
        seen.tx_level       = tx_level_o;
        seen.tx_active      = tx_active_o;
        seen.write_rejected = write_rejected_o;
        seen.read_empty     = read_empty_o;
        seen.rx_dropped     = rx_dropped_o;
        seen.drop_total     = drop_total_o;
        seen.overrun_total  = overrun_total_o;
        sb.check_word(seen, $time);
      end
      if (in_valid_i && in_ready_o) sb.note_request(req_type_i, data_in_i);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  // one request word; valid only drops when the sender decides to idle
  task automatic push_word(input logic [TYPE_W-1:0] kind, input logic [BYTE_W-1:0] din);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    data_in_i  <= din;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // sender holds off until every predicted word has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due_words.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // register write, only issued with the block idle
  task automatic cfg_write(input cfg_e idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // bursts biased toward filling or draining one ring, plus plain noise
  task automatic run_random(input int count);
    int n;
    int len;
    int k;
    int r;
    int mix;
    logic [TYPE_W-1:0] t;
    n = 0;
    while (n < count) begin
      mix = $urandom_range(0, 4);
      len = $urandom_range(4, 120);
      for (k = 0; k < len && n < count; k++) begin
        r = $urandom_range(0, 99);
        case (mix)
          0: t = (r < 80) ? REQ_RX_BYTE : (r < 88) ? REQ_HOST_RD :
                 (r < 94) ? REQ_RX_BREAK : REQ_RX_IDLE;
          1: t = (r < 70) ? REQ_HOST_RD : (r < 88) ? REQ_RX_BYTE : REQ_RX_BREAK;
          2: t = (r < 85) ? REQ_HOST_WR : REQ_TX_READY;
          3: t = (r < 75) ? REQ_TX_READY : (r < 90) ? REQ_HOST_WR : REQ_EVENT;
          default: t = TYPE_W'($urandom_range(0, 7));
        endcase
        push_word(t, BYTE_W'($urandom));
        n++;
      end
    end
  endtask

  initial begin : stimulus
    int trig_plan [6];
    int p;
    int i;
    int guard;

    trig_plan = '{0, 63, 1, 47, 5, 31};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners with reset config: trigger 16, idle-line framing
    push_word(REQ_HOST_RD, 8'h00);     // read from an empty receive ring
    push_word(REQ_TX_READY, 8'h00);    // transmitter ready with interrupt off
    push_word(REQ_RX_BREAK, 8'h00);    // break with nothing stored
    push_word(REQ_RX_IDLE, 8'h00);     // idle line in idle framing
    push_word(REQ_RESERVED, 8'hFF);    // unused request code
    push_word(REQ_RX_BYTE, 8'h00);
    push_word(REQ_RX_BYTE, 8'hFF);
    push_word(REQ_RX_BYTE, 8'hA5);
    push_word(REQ_RX_BREAK, 8'h00);    // drops the newest byte
    push_word(REQ_HOST_RD, 8'h00);
    push_word(REQ_HOST_RD, 8'h00);
    push_word(REQ_HOST_RD, 8'h00);
    push_word(REQ_HOST_WR, 8'hFF);
    push_word(REQ_HOST_WR, 8'h00);
    push_word(REQ_TX_READY, 8'h00);
    push_word(REQ_TX_READY, 8'h00);
    push_word(REQ_TX_READY, 8'h00);    // ring empty, interrupt goes off
    push_word(REQ_HOST_WR, 8'h5A);
    push_word(REQ_EVENT, 8'h01);       // flush keeps the interrupt on
    push_word(REQ_TX_READY, 8'h00);
    push_word(REQ_EVENT, 8'h00);       // overrun
    push_word(REQ_EVENT, 8'hFE);       // overrun, upper data bits set

    // both rings to full and one past, then back to empty
    for (i = 0; i < TX_DEPTH + 1; i++) push_word(REQ_HOST_WR, BYTE_W'($urandom));
    for (i = 0; i < TX_DEPTH + 1; i++) push_word(REQ_TX_READY, 8'h00);
    for (i = 0; i < RX_DEPTH + 1; i++) push_word(REQ_RX_BYTE, BYTE_W'($urandom));
    for (i = 0; i < RX_DEPTH + 1; i++) push_word(REQ_HOST_RD, 8'h00);

    // random phases, each after a config change with the block drained
    for (p = 0; p < 6; p++) begin
      drain();
      if (p == 3) trig_plan[p] = $urandom_range(0, 63);
      cfg_write(CFG_RX_TRIGGER, CFG_W'(trig_plan[p]));
      cfg_write(CFG_BREAK_MODE, CFG_W'(p % 2 == 0));
      if (p < 2) begin
        send_idle = 6;
        recv_idle = 63;
      end else if (p < 4) begin
        send_idle = 63;
        recv_idle = 6;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      run_random(225);
    end

    // full receive ring, then a run of drops and overruns
    drain();
    for (i = 0; i < RX_DEPTH + 8; i++) push_word(REQ_RX_BYTE, BYTE_W'($urandom));
    for (i = 0; i < 8; i++) push_word(REQ_EVENT, {7'($urandom), 1'b0});
    run_random(20);

    // wait out the tail, bounded
    in_valid_i <= 1'b0;
    guard = 0;
    while (sb.due_words.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    sb.leftover_check($time);
    if (sb.fail_count == 0) begin
      $display("uart_fifo_controller_core test passed");
    end else begin
      $display("uart_fifo_controller_core test failed");
    end
    $finish;
  end

endmodule
